FILE: rtl/core/kdlsp_pkg.sv
package kdlsp_pkg;

    localparam int TIME_WIDTH = 16;
    localparam int CFG_WIDTH  = 16;
    localparam int CMP_WIDTH  = (TIME_WIDTH > CFG_WIDTH) ? TIME_WIDTH : CFG_WIDTH;
    localparam int ADDR_WIDTH = 4;

    localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = CFG_WIDTH'(50);
    localparam logic [CFG_WIDTH-1:0] COOLDOWN_RESET   = CFG_WIDTH'(200);
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = CFG_WIDTH'(2000);

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_COOLDOWN   = 2'd1,
        REG_LONG_PRESS = 2'd2,
        REG_NONE       = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_SHORT      = 3'd1,
        EV_REJ_MASTER = 3'd2,
        EV_REJ_AUTO   = 3'd3,
        EV_LONG       = 3'd4
    } event_t;

endpackage

FILE: rtl/core/key_debounce_long_short_press_unit.sv
// Channel  | Dir | Fields (tdata, lsb first)
// ---------+-----+----------------------------------------------------------
// s_axis   | in  | [0] key_level, [1] master_on, [7:2] zero
// m_axis   | out | [1:0] relay_state, [2] auto_on, [3] key_held,
//          |     | [6:4] event_res, [7] zero
// apb      | in  | 0x0 debounce_ms, 0x4 cooldown_ms, 0x8 long_hold_ms
//
// One tick per cycle sustained while the result is not stalled; a tick passes
// through the input register, then the result register fed by the tick update logic.
// Reset: asynchronous, active low; auto mode on, all counters and flags zero.
// A stalled result holds the output register; the input register still takes
// a tick, so s_tready only drops while both registers are full and stalled.
module key_debounce_long_short_press_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // key_level, master_on
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,   // relay_state, auto_on,
                                                            // key_held, event_res
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kdlsp_pkg::ADDR_WIDTH-1:0]     paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int TW = kdlsp_pkg::TIME_WIDTH;
    localparam int CW = kdlsp_pkg::CMP_WIDTH;

    // configuration
    logic [kdlsp_pkg::CFG_WIDTH-1:0] debounce_reg, cooldown_reg, long_press_reg;
    kdlsp_pkg::reg_idx_t             reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = kdlsp_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg   <= kdlsp_pkg::DEBOUNCE_RESET;
            cooldown_reg   <= kdlsp_pkg::COOLDOWN_RESET;
            long_press_reg <= kdlsp_pkg::LONG_PRESS_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                kdlsp_pkg::REG_DEBOUNCE:   debounce_reg   <= pwdata[kdlsp_pkg::CFG_WIDTH-1:0];
                kdlsp_pkg::REG_COOLDOWN:   cooldown_reg   <= pwdata[kdlsp_pkg::CFG_WIDTH-1:0];
                kdlsp_pkg::REG_LONG_PRESS: long_press_reg <= pwdata[kdlsp_pkg::CFG_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            kdlsp_pkg::REG_DEBOUNCE:   prdata = 32'(debounce_reg);
            kdlsp_pkg::REG_COOLDOWN:   prdata = 32'(cooldown_reg);
            kdlsp_pkg::REG_LONG_PRESS: prdata = 32'(long_press_reg);
            default:                   prdata = 32'd0;
        endcase
    end

    // pipeline control
    logic in_valid_reg, key_in_reg, master_in_reg;
    logic out_valid_reg;
    logic advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;

    // tick state
    logic          raw_prev_reg, stable_level_reg, press_active_reg, long_done_reg;
    logic          auto_reg;
    logic [1:0]    relay_reg;
    logic [TW-1:0] stable_ticks_reg, release_ticks_reg, hold_ticks_reg;

    logic          raw_prev_next, stable_level_next, press_active_next, long_done_next;
    logic          auto_next;
    logic [1:0]    relay_next;
    logic [TW-1:0] stable_ticks_next, release_ticks_next, hold_ticks_next;
    kdlsp_pkg::event_t ev_next;
    logic          go;

    logic [TW-1:0] stable_inc, release_inc, hold_inc;

    assign stable_inc  = (stable_ticks_reg  == kdlsp_pkg::TIME_MAX) ? stable_ticks_reg
                                                                    : stable_ticks_reg + 1'b1;
    assign release_inc = (release_ticks_reg == kdlsp_pkg::TIME_MAX) ? release_ticks_reg
                                                                    : release_ticks_reg + 1'b1;
    assign hold_inc    = (hold_ticks_reg    == kdlsp_pkg::TIME_MAX) ? hold_ticks_reg
                                                                    : hold_ticks_reg + 1'b1;

    always_comb
    begin
        raw_prev_next      = raw_prev_reg;
        stable_level_next  = stable_level_reg;
        press_active_next  = press_active_reg;
        long_done_next     = long_done_reg;
        auto_next          = auto_reg;
        relay_next         = relay_reg;
        stable_ticks_next  = stable_inc;
        release_ticks_next = release_inc;
        hold_ticks_next    = hold_inc;
        ev_next            = kdlsp_pkg::EV_NONE;
        go                 = 1'b0;

        if (key_in_reg != raw_prev_reg)
        begin
            raw_prev_next     = key_in_reg;
            stable_ticks_next = '0;
        end
        else if (CW'(stable_inc) >= CW'(debounce_reg))
        begin
            go = 1'b1;
            if (key_in_reg != stable_level_reg)
            begin
                stable_level_next = key_in_reg;
                if (key_in_reg)
                begin
                    if (CW'(release_inc) < CW'(cooldown_reg))
                        go = 1'b0;   // press inside cooldown
                    else
                    begin
                        press_active_next = 1'b1;
                        hold_ticks_next   = '0;
                        long_done_next    = 1'b0;
                    end
                end
                else
                begin
                    if (press_active_reg && !long_done_reg)
                    begin
                        if (CW'(hold_inc) < CW'(long_press_reg))
                        begin
                            if (!master_in_reg)
                                ev_next = kdlsp_pkg::EV_REJ_MASTER;
                            else if (auto_reg)
                                ev_next = kdlsp_pkg::EV_REJ_AUTO;
                            else
                            begin
                                relay_next = relay_reg + 1'b1;
                                ev_next    = kdlsp_pkg::EV_SHORT;
                            end
                        end
                        else
                        begin
                            ev_next   = kdlsp_pkg::EV_LONG;
                            auto_next = !auto_reg;
                            if (!auto_reg)
                                relay_next = 2'd0;
                        end
                    end
                    press_active_next  = 1'b0;
                    long_done_next     = 1'b0;
                    release_ticks_next = '0;
                end
            end
        end

        // long press reached while held; release already cleared press_active
        if (go && press_active_next && !long_done_next &&
            CW'(hold_ticks_next) >= CW'(long_press_reg))
        begin
            long_done_next = 1'b1;
            ev_next        = kdlsp_pkg::EV_LONG;
            auto_next      = !auto_reg;
            if (!auto_reg)
                relay_next = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            raw_prev_reg      <= 1'b0;
            stable_level_reg  <= 1'b0;
            press_active_reg  <= 1'b0;
            long_done_reg     <= 1'b0;
            auto_reg          <= 1'b1;
            relay_reg         <= 2'd0;
            stable_ticks_reg  <= '0;
            release_ticks_reg <= '0;
            hold_ticks_reg    <= '0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
            begin
                out_valid_reg     <= 1'b1;
                raw_prev_reg      <= raw_prev_next;
                stable_level_reg  <= stable_level_next;
                press_active_reg  <= press_active_next;
                long_done_reg     <= long_done_next;
                auto_reg          <= auto_next;
                relay_reg         <= relay_next;
                stable_ticks_reg  <= stable_ticks_next;
                release_ticks_reg <= release_ticks_next;
                hold_ticks_reg    <= hold_ticks_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            key_in_reg    <= s_tdata[0];
            master_in_reg <= s_tdata[1];
        end
        if (advance)
            m_tdata <= {1'b0, ev_next, press_active_next, auto_next, relay_next};
    end

endmodule

FILE: rtl/core/kdlsp_checker.sv
module kdlsp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    logic [2:0] ev;
    assign ev = m_tdata[6:4];

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ev <= kdlsp_pkg::EV_LONG)
        else $error("event code out of range");

    // short press is only applied on release in manual mode
    a_short: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ev == kdlsp_pkg::EV_SHORT |-> !m_tdata[2] && !m_tdata[3])
        else $error("short press applied in auto mode or while held");

    a_rej_auto: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ev == kdlsp_pkg::EV_REJ_AUTO |-> m_tdata[2] && !m_tdata[3])
        else $error("auto rejection outside auto mode");

    // entering auto mode clears the relay mode
    a_long_auto: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ev == kdlsp_pkg::EV_LONG && m_tdata[2] |-> m_tdata[1:0] == 2'd0)
        else $error("relay not cleared on entering auto mode");

endmodule

bind key_debounce_long_short_press_unit kdlsp_checker u_kdlsp_checker (.*);

FILE: verif/testbench.sv
module testbench;
    import kdlsp_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 4;

    typedef struct {
        logic [1:0] relay;
        logic       auto_on;
        logic       held;
        event_t     ev;
    } status_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;    // [0] key_level, [1] master_on, [7:2] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;         // [1:0] relay_state, [2] auto_on, [3] key_held,
                                            // [6:4] event_res, [7] zero
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_WIDTH-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    key_debounce_long_short_press_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor state
    logic [CFG_WIDTH-1:0]  cfg_debounce = DEBOUNCE_RESET;
    logic [CFG_WIDTH-1:0]  cfg_cooldown = COOLDOWN_RESET;
    logic [CFG_WIDTH-1:0]  cfg_long = LONG_PRESS_RESET;
    logic                  raw_last = 1'b0;
    logic                  level_ok = 1'b0;
    logic [TIME_WIDTH-1:0] stable_cnt = '0;
    logic [TIME_WIDTH-1:0] release_cnt = '0;
    logic [TIME_WIDTH-1:0] hold_cnt = '0;
    logic                  pressing = 1'b0;
    logic                  long_fired = 1'b0;
    logic                  auto_now = 1'b1;
    logic [1:0]            relay_now = 2'd0;

    logic [1:0] tick_backlog[$];     // {master_on, key_level}
    status_t    predicted_status[$];
    bit         xfer_done = 1'b0;
    int         ticks_issued = 0;
    int         ticks_taken = 0;
    int         results_seen = 0;
    int         mismatches = 0;
    int         settings_run = 0;
    int         n_short = 0;
    int         n_reject = 0;
    int         n_long = 0;
    int         tx_idle_pct = 0;
    int         rx_idle_pct = 0;
    int         tx_burst = 0;
    int         rx_burst = 0;

    function event_t fire_long();
        long_fired = 1'b1;
        auto_now = !auto_now;
        if (auto_now)
            relay_now = 2'd0;
        return EV_LONG;
    endfunction

    task automatic advance_model(input logic key, input logic master, output status_t st);
        event_t ev;
        bit     ignored;
        ev = EV_NONE;
        ignored = 1'b0;
        stable_cnt = (stable_cnt == TIME_MAX) ? stable_cnt : stable_cnt + 1'b1;
        release_cnt = (release_cnt == TIME_MAX) ? release_cnt : release_cnt + 1'b1;
        hold_cnt = (hold_cnt == TIME_MAX) ? hold_cnt : hold_cnt + 1'b1;
        if (key != raw_last)
        begin
            raw_last = key;
            stable_cnt = '0;
        end
        else if (stable_cnt >= cfg_debounce)
        begin
            if (key != level_ok)
            begin
                level_ok = key;
                if (key)
                begin
                    if (release_cnt < cfg_cooldown)
                        ignored = 1'b1;
                    else
                    begin
                        pressing = 1'b1;
                        hold_cnt = '0;
                        long_fired = 1'b0;
                    end
                end
                else
                begin
                    if (pressing && !long_fired)
                    begin
                        if (hold_cnt >= cfg_long)
                            ev = fire_long();
                        else if (!master)
                            ev = EV_REJ_MASTER;
                        else if (auto_now)
                            ev = EV_REJ_AUTO;
                        else
                        begin
                            relay_now = relay_now + 2'd1;
                            ev = EV_SHORT;
                        end
                    end
                    pressing = 1'b0;
                    long_fired = 1'b0;
                    release_cnt = '0;
                end
            end
            if (!ignored && pressing && !long_fired && hold_cnt >= cfg_long)
                ev = fire_long();
        end
        st.relay = relay_now;
        st.auto_on = auto_now;
        st.held = pressing;
        st.ev = ev;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
        mismatches++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout with %0d results outstanding", predicted_status.size());
        $display("FAIL key_debounce_long_short_press_unit");
        $finish;
    end

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else if (!s_tvalid || xfer_done)
        begin
            if (tx_burst > 0)
                tx_burst--;
            else if ($urandom_range(99) < 2)
                tx_burst = $urandom_range(30, 10);
            if (tick_backlog.size() > 0
                && (tx_burst > 0 || $urandom_range(99) >= tx_idle_pct))
            begin
                s_tdata <= {6'd0, tick_backlog.pop_front()};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (rx_burst > 0)
            rx_burst--;
        else if ($urandom_range(99) < 2)
            rx_burst = $urandom_range(30, 10);
        m_tready <= (rx_burst > 0) || ($urandom_range(99) >= rx_idle_pct);
    end

    // monitor and prediction
    always @(posedge clk)
    begin : monitor
        status_t want;
        status_t next;
        xfer_done = rst_n && s_tvalid && s_tready;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (predicted_status.size() == 0)
                    report_mismatch("result with none pending, tdata", int'(m_tdata), 0);
                else
                begin
                    want = predicted_status.pop_front();
                    if (m_tdata[1:0] !== want.relay)
                        report_mismatch("relay_state", int'(m_tdata[1:0]), int'(want.relay));
                    if (m_tdata[2] !== want.auto_on)
                        report_mismatch("auto_on", int'(m_tdata[2]), int'(want.auto_on));
                    if (m_tdata[3] !== want.held)
                        report_mismatch("key_held", int'(m_tdata[3]), int'(want.held));
                    if (m_tdata[6:4] !== want.ev)
                        report_mismatch("event_res", int'(m_tdata[6:4]), int'(want.ev));
                    case (want.ev)
                        EV_SHORT:                   n_short++;
                        EV_REJ_MASTER, EV_REJ_AUTO: n_reject++;
                        EV_LONG:                    n_long++;
                        default: ;
                    endcase
                end
                results_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                advance_model(s_tdata[0], s_tdata[1], next);
                predicted_status.push_back(next);
                ticks_taken++;
            end
        end
    end

    task automatic push_ticks(input logic key, input logic master, input int count);
        repeat (count)
        begin
            tick_backlog.push_back({master, key});
            ticks_issued++;
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (ticks_taken != ticks_issued || predicted_status.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input reg_idx_t idx, input bit wr, input logic [15:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= {16'd0, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (!wr && prdata !== {16'd0, val})
            report_mismatch("register readback", int'(prdata), int'(val));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_timing(input logic [15:0] db, input logic [15:0] cd,
                              input logic [15:0] lp);
        apb_access(REG_DEBOUNCE, 1'b1, db);
        apb_access(REG_COOLDOWN, 1'b1, cd);
        apb_access(REG_LONG_PRESS, 1'b1, lp);
        cfg_debounce = db;
        cfg_cooldown = cd;
        cfg_long = lp;
        apb_access(REG_DEBOUNCE, 1'b0, db);
        apb_access(REG_COOLDOWN, 1'b0, cd);
        apb_access(REG_LONG_PRESS, 1'b0, lp);
        settings_run++;
    endtask

    // mostly well-formed presses sized around the current timing, plus glitches and noise
    task automatic gen_ticks(input int n);
        int   added;
        int   confirm_len;
        int   hold_len;
        int   rel_len;
        int   glitch_max;
        int   sel;
        int   k;
        logic m;
        added = 0;
        confirm_len = (cfg_debounce == 0) ? 2 : int'(cfg_debounce) + 1;
        glitch_max = (cfg_debounce < 1) ? 1 : (cfg_debounce > 50) ? 50 : int'(cfg_debounce);
        while (added < n)
        begin
            sel = $urandom_range(99);
            m = ($urandom_range(99) < 80);
            if (sel < 70)
            begin
                case ($urandom_range(2))
                    0:       hold_len = confirm_len + $urandom_range(3);
                    1:       hold_len = confirm_len + int'(cfg_long) + $urandom_range(4) - 2;
                    default: hold_len = confirm_len + int'(cfg_long) + $urandom_range(12);
                endcase
                rel_len = confirm_len + $urandom_range(int'(cfg_cooldown) + 4);
                if (hold_len > 250)
                    hold_len = 250;
                if (rel_len > 250)
                    rel_len = 250;
                if (hold_len > n - added)
                    hold_len = n - added;
                if (rel_len > n - added - hold_len)
                    rel_len = n - added - hold_len;
                for (k = 0; k < hold_len + rel_len; k++)
                begin
                    if ($urandom_range(99) < 5)
                        m = !m;
                    push_ticks(k < hold_len, m, 1);
                end
                added += hold_len + rel_len;
            end
            else if (sel < 85)
            begin
                hold_len = $urandom_range(glitch_max, 1);
                rel_len = $urandom_range(3, 1);
                push_ticks(1'b1, m, hold_len);
                push_ticks(1'b0, m, rel_len);
                added += hold_len + rel_len;
            end
            else
            begin
                hold_len = $urandom_range(6, 1);
                for (k = 0; k < hold_len; k++)
                    push_ticks(1'($urandom_range(1)), 1'($urandom_range(1)), 1);
                added += hold_len;
            end
        end
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:
            begin
                tx_idle_pct = 61;
                rx_idle_pct = 0;
            end
            2:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 61;
            end
            3:
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 26;
            end
            default:
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
        endcase
    endtask

    task automatic run_phase(input logic [15:0] db, input logic [15:0] cd,
                             input logic [15:0] lp, input int n, input int mode);
        wait_idle();
        set_timing(db, cd, lp);
        set_idling(mode);
        gen_ticks(n);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apb_access(REG_DEBOUNCE, 1'b0, DEBOUNCE_RESET);
        apb_access(REG_COOLDOWN, 1'b0, COOLDOWN_RESET);
        apb_access(REG_LONG_PRESS, 1'b0, LONG_PRESS_RESET);

        // directed: rejected in auto, long toggle, rejected master off, applied short
        set_timing(16'd0, 16'd0, 16'd4);
        push_ticks(1'b1, 1'b1, 3);
        push_ticks(1'b0, 1'b1, 2);
        push_ticks(1'b1, 1'b1, 6);
        push_ticks(1'b0, 1'b1, 2);
        push_ticks(1'b1, 1'b0, 3);
        push_ticks(1'b0, 1'b0, 2);
        push_ticks(1'b1, 1'b1, 3);
        push_ticks(1'b0, 1'b1, 2);

        run_phase(16'd1, 16'd3, 16'd6, 150, 1);
        wait_idle();
        gen_ticks(150);
        run_phase(16'd0, 16'd0, 16'd0, 150, 2);
        run_phase(16'd3, 16'd10, 16'd12, 300, 3);
        run_phase(16'd2, 16'd0, 16'hFFFF, 150, 0);
        run_phase(16'hFFFF, 16'd5, 16'd5, 60, 1);
        run_phase(16'd1, 16'hFFFF, 16'd3, 60, 2);
        run_phase(16'd0, 16'd2, 16'd1, 250, 3);
        run_phase(16'd5, 16'd20, 16'd30, 250, 0);
        run_phase(16'($urandom_range(4)), 16'($urandom_range(30)), 16'($urandom_range(40)),
                  300, 1);
        wait_idle();

        if (predicted_status.size() != 0)
            report_mismatch("results never delivered", 0, predicted_status.size());
        $display("%0d ticks checked across %0d timing settings and four idling patterns",
                 results_seen, settings_run);
        $display("short presses %0d, rejected presses %0d, long toggles %0d, mismatches %0d",
                 n_short, n_reject, n_long, mismatches);
        if (mismatches == 0)
            $display("PASS key_debounce_long_short_press_unit");
        else
            $display("FAIL key_debounce_long_short_press_unit");
        $finish;
    end

endmodule
